// ===== rtl/core/aapd_pkg.sv =====
// Shared constants, a type and a helper function of the area-average downscaler.
`timescale 1ns / 1ps

package aapd_pkg;

    localparam int MAX_THUMB_WIDTH_DEF = 64;

    localparam logic [15:0] SRC_WIDTH_RST   = 16'd320;
    localparam logic [15:0] SRC_HEIGHT_RST  = 16'd240;
    localparam logic [6:0]  THUMB_WIDTH_RST = 7'd64;
    localparam logic [15:0] THUMB_HEIGHT_RST = 16'd48;

    localparam logic [1:0] CFG_SRC_WIDTH    = 2'd0;
    localparam logic [1:0] CFG_SRC_HEIGHT   = 2'd1;
    localparam logic [1:0] CFG_THUMB_WIDTH  = 2'd2;
    localparam logic [1:0] CFG_THUMB_HEIGHT = 2'd3;

    // One source pixel spans this many units in 16.16 coordinates.
    localparam logic [32:0] UNIT_SPAN = 33'h1_0000;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    // Length of the overlap of [a0, a1) with the unit span that begins at start.
    function automatic logic [16:0] overlap(input logic [31:0] a0, input logic [31:0] a1,
                                            input logic [31:0] start);
        logic [32:0] lo;
        logic [32:0] hi;
        logic [32:0] span_end;
        span_end = {1'b0, start} + UNIT_SPAN;
        lo = (a0 > start) ? {1'b0, a0} : {1'b0, start};
        hi = ({1'b0, a1} < span_end) ? {1'b0, a1} : span_end;
        return (hi > lo) ? 17'(hi - lo) : 17'd0;
    endfunction

endpackage

// ===== rtl/core/aapd_div.sv =====
// Radix-2 restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module aapd_div #(
    parameter int W = 64
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start,
    input  logic [W-1:0]        dividend,
    input  logic [W-1:0]        divisor,
    output logic [W-1:0]        quotient,
    output aapd_pkg::div_stat_t status
);
    import aapd_pkg::*;

    localparam int CW = $clog2(W + 1);

    logic [W-1:0]  rem_reg;
    logic [W-1:0]  quot_reg;
    logic [W-1:0]  dvs_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic          done_reg;

    logic [W:0]    shifted;
    logic          ge;
    logic [W:0]    diff;

    assign shifted = {rem_reg, quot_reg[W-1]};
    assign ge      = shifted >= {1'b0, dvs_reg};
    assign diff    = shifted - {1'b0, dvs_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= CW'(W);
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg - CW'(1);
            if (cnt_reg == CW'(1)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg  <= '0;
            quot_reg <= dividend;
            dvs_reg  <= divisor;
        end else if (busy_reg) begin
            rem_reg  <= ge ? diff[W-1:0] : shifted[W-1:0];
            quot_reg <= {quot_reg[W-2:0], ge};
        end
    end

    assign quotient    = quot_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

// ===== rtl/core/area_average_pixel_downscaler.sv =====
// Top level of the area-average RGB565 downscaler with its accumulator memories.
//
//   channel | direction | signals
//   s_      | in        | s_valid, s_ready, s_pixel_rgb565
//   m_      | out       | m_valid, m_ready, m_thumb_pixel, m_row_last, m_frame_last
//   cfg_    | in        | cfg_write_en, cfg_index, cfg_data (write only)
//
// A source pixel passes through ST_WY, then ST_C_ADDR, ST_C_MUL1, ST_C_MUL2 and
// ST_C_ADD for each thumbnail cell it touches (one read-modify-write of both
// accumulator memories per cell), then ST_P_END. At the end of a source row that
// closes a thumbnail row, each of up to MAX_THUMB_WIDTH results is divided by the
// 64-bit one-bit-per-cycle dividers. After reset and after each register write
// the cell steps are recomputed by the step divider, during which no pixel is
// accepted. Valid bits clear the accumulators at once; there is no clearing pass.
// The output register lets the next pixel be taken while the last result still waits.
`timescale 1ns / 1ps

module area_average_pixel_downscaler #(
    parameter int MAX_THUMB_WIDTH = aapd_pkg::MAX_THUMB_WIDTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [15:0] s_pixel_rgb565,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [15:0] m_thumb_pixel,
    output logic        m_row_last,
    output logic        m_frame_last,
    input  logic        cfg_write_en,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import aapd_pkg::*;

    localparam int DX_W = (MAX_THUMB_WIDTH > 1) ? $clog2(MAX_THUMB_WIDTH) : 1;
    localparam logic [6:0] TW_MAX = 7'(MAX_THUMB_WIDTH);

    localparam logic [4:0] ST_IDLE   = 5'd0;
    localparam logic [4:0] ST_CFG_XW = 5'd1;
    localparam logic [4:0] ST_CFG_YW = 5'd2;
    localparam logic [4:0] ST_WY     = 5'd3;
    localparam logic [4:0] ST_C_ADDR = 5'd4;
    localparam logic [4:0] ST_C_MUL1 = 5'd5;
    localparam logic [4:0] ST_C_MUL2 = 5'd6;
    localparam logic [4:0] ST_C_ADD  = 5'd7;
    localparam logic [4:0] ST_P_END  = 5'd8;
    localparam logic [4:0] ST_E_RD   = 5'd9;
    localparam logic [4:0] ST_E_MUL  = 5'd10;
    localparam logic [4:0] ST_E_NUM  = 5'd11;
    localparam logic [4:0] ST_E_WAIT = 5'd12;
    localparam logic [4:0] ST_E_OUT  = 5'd13;
    localparam logic [4:0] ST_E_SWAP = 5'd14;

    // Configuration registers.
    logic [15:0] sw_cfg_reg, sh_cfg_reg, th_cfg_reg;
    logic [6:0]  tw_cfg_reg;
    logic        dirty_reg;

    logic [15:0] eff_sw, eff_sh, eff_th;
    logic [6:0]  eff_tw;
    logic [31:0] srcw, srch;
    logic [16:0] th17;

    assign eff_sw = (sw_cfg_reg == 16'd0) ? 16'd1 : sw_cfg_reg;
    assign eff_sh = (sh_cfg_reg == 16'd0) ? 16'd1 : sh_cfg_reg;
    assign eff_th = (th_cfg_reg == 16'd0) ? 16'd1 : th_cfg_reg;
    assign eff_tw = (tw_cfg_reg == 7'd0) ? 7'd1 :
                    ((tw_cfg_reg > TW_MAX) ? TW_MAX : tw_cfg_reg);
    assign srcw = {eff_sw, 16'h0000};
    assign srch = {eff_sh, 16'h0000};
    assign th17 = {1'b0, eff_th};

    // Control state.
    logic [4:0]      state_reg;
    logic [15:0]     col_reg, row_reg, thumb_row_reg;
    logic [31:0]     top_reg, bottom_reg;
    logic [31:0]     xstep_reg, ystep_reg;
    logic [DX_W-1:0] dx_reg;
    logic [31:0]     x0_reg;
    logic            cur_bank_reg;
    logic [MAX_THUMB_WIDTH-1:0] valid0_reg, valid1_reg;
    logic            adv_reg, cont_reg;
    logic            m_valid_reg;

    // Payload registers.
    logic [15:0] pix_reg;
    logic [16:0] wx_reg, wy0_reg, wy1_reg;
    logic [33:0] p0_reg, p1_reg;
    logic [39:0] r0_reg, g0_reg, b0_reg, r1_reg, g1_reg, b1_reg;
    logic [63:0] total_reg;
    logic [15:0] px_reg;
    logic [15:0] thumb_pixel_reg;
    logic        row_last_reg, frame_last_reg;

    // Accumulator memories: one bank holds the current thumbnail row, the other the next.
    logic [191:0] mem0 [MAX_THUMB_WIDTH];
    logic [191:0] mem1 [MAX_THUMB_WIDTH];
    logic [191:0] rd0_reg, rd1_reg;
    logic         mem_rd_en, mem_we;
    logic [191:0] wd0, wd1;

    always_ff @(posedge aclk) begin
        if (mem_rd_en) begin
            rd0_reg <= mem0[dx_reg];
            rd1_reg <= mem1[dx_reg];
        end
        if (mem_we) begin
            mem0[dx_reg] <= wd0;
            mem1[dx_reg] <= wd1;
        end
    end

    // Dividers.
    logic        step_start;
    logic [31:0] step_dividend, step_divisor, step_q;
    div_stat_t   step_stat;

    assign step_dividend = (state_reg == ST_IDLE) ? srcw : srch;
    assign step_divisor  = (state_reg == ST_IDLE) ? {25'd0, eff_tw} : {16'd0, eff_th};

    aapd_div #(.W(32)) u_step_div (
        .aclk(aclk), .aresetn(aresetn), .start(step_start),
        .dividend(step_dividend), .divisor(step_divisor),
        .quotient(step_q), .status(step_stat)
    );

    logic        avg_start;
    logic [63:0] num_r, num_g, num_b, q_r, q_g, q_b;
    div_stat_t   stat_r, stat_g, stat_b;

    aapd_div #(.W(64)) u_div_r (
        .aclk(aclk), .aresetn(aresetn), .start(avg_start),
        .dividend(num_r), .divisor(total_reg), .quotient(q_r), .status(stat_r)
    );
    aapd_div #(.W(64)) u_div_g (
        .aclk(aclk), .aresetn(aresetn), .start(avg_start),
        .dividend(num_g), .divisor(total_reg), .quotient(q_g), .status(stat_g)
    );
    aapd_div #(.W(64)) u_div_b (
        .aclk(aclk), .aresetn(aresetn), .start(avg_start),
        .dividend(num_b), .divisor(total_reg), .quotient(q_b), .status(stat_b)
    );

    // Shared datapath terms.
    logic        last_cell;
    logic [31:0] x1;
    logic [31:0] cstart;
    logic [32:0] cend;
    logic [16:0] wx;
    logic [16:0] tr17;
    logic [31:0] rstart, y2;
    logic [16:0] wy0_c, wy1_c;
    logic [33:0] p0_c, p1_c;
    logic [39:0] r0_c, g0_c, b0_c, r1_c, g1_c, b1_c;
    logic [191:0] cur_data, nxt_data, new_cur, new_nxt;
    logic [31:0] cell_len, ylen;
    logic [63:0] total_c;
    logic [15:0] px_c;
    logic        accept;
    logic        out_free;
    logic        row_done;
    logic        emit_cond;
    logic [15:0] new_tr;

    assign last_cell = (7'(dx_reg) + 7'd1) == eff_tw;
    assign x1        = last_cell ? srcw : (x0_reg + xstep_reg);
    assign cstart    = {col_reg, 16'h0000};
    assign cend      = {1'b0, cstart} + UNIT_SPAN;
    assign wx        = overlap(x0_reg, x1, cstart);

    assign tr17   = {1'b0, thumb_row_reg};
    assign rstart = {row_reg, 16'h0000};
    assign y2     = ((tr17 + 17'd2) >= th17) ? srch : (bottom_reg + ystep_reg);
    assign wy0_c  = overlap(top_reg, bottom_reg, rstart);
    assign wy1_c  = ((tr17 + 17'd1) < th17) ? overlap(bottom_reg, y2, rstart) : 17'd0;

    assign p0_c = wx_reg * wy0_reg;
    assign p1_c = wx_reg * wy1_reg;
    assign r0_c = pix_reg[15:11] * p0_reg;
    assign g0_c = pix_reg[10:5] * p0_reg;
    assign b0_c = pix_reg[4:0] * p0_reg;
    assign r1_c = pix_reg[15:11] * p1_reg;
    assign g1_c = pix_reg[10:5] * p1_reg;
    assign b1_c = pix_reg[4:0] * p1_reg;

    // An entry whose valid bit is clear reads as zero.
    always_comb begin
        if (cur_bank_reg) begin
            cur_data = valid1_reg[dx_reg] ? rd1_reg : '0;
            nxt_data = valid0_reg[dx_reg] ? rd0_reg : '0;
        end else begin
            cur_data = valid0_reg[dx_reg] ? rd0_reg : '0;
            nxt_data = valid1_reg[dx_reg] ? rd1_reg : '0;
        end
    end

    assign new_cur = {cur_data[191:128] + {24'd0, r0_reg},
                      cur_data[127:64] + {24'd0, g0_reg},
                      cur_data[63:0] + {24'd0, b0_reg}};
    assign new_nxt = {nxt_data[191:128] + {24'd0, r1_reg},
                      nxt_data[127:64] + {24'd0, g1_reg},
                      nxt_data[63:0] + {24'd0, b1_reg}};
    assign wd0 = cur_bank_reg ? new_nxt : new_cur;
    assign wd1 = cur_bank_reg ? new_cur : new_nxt;

    assign cell_len = x1 - x0_reg;
    assign ylen     = bottom_reg - top_reg;
    assign total_c  = cell_len * ylen;
    assign num_r    = cur_data[191:128] + {1'b0, total_reg[63:1]};
    assign num_g    = cur_data[127:64] + {1'b0, total_reg[63:1]};
    assign num_b    = cur_data[63:0] + {1'b0, total_reg[63:1]};
    assign px_c     = (total_reg == 64'd0) ? 16'd0 :
                      ({q_r[4:0], 11'd0} | {q_g[10:0], 5'd0} | q_b[15:0]);

    assign s_ready   = (state_reg == ST_IDLE) && !dirty_reg && !cfg_write_en;
    assign accept    = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;
    assign row_done  = ({1'b0, col_reg} + 17'd1) >= {1'b0, eff_sw};
    assign emit_cond = (tr17 < th17) &&
                       ({({1'b0, row_reg} + 17'd1), 16'h0000} >= {1'b0, bottom_reg});
    assign new_tr    = thumb_row_reg + 16'd1;

    assign mem_rd_en  = ((state_reg == ST_C_ADDR) && ({1'b0, x1} > {1'b0, cstart}) &&
                         (wx != 17'd0)) || (state_reg == ST_E_RD);
    assign mem_we     = state_reg == ST_C_ADD;
    assign step_start = ((state_reg == ST_IDLE) && dirty_reg) ||
                        ((state_reg == ST_CFG_XW) && step_stat.done && !step_stat.busy);
    assign avg_start  = state_reg == ST_E_NUM;

    // Configuration writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sw_cfg_reg <= SRC_WIDTH_RST;
            sh_cfg_reg <= SRC_HEIGHT_RST;
            tw_cfg_reg <= THUMB_WIDTH_RST;
            th_cfg_reg <= THUMB_HEIGHT_RST;
        end else if (cfg_write_en) begin
            case (cfg_index)
                CFG_SRC_WIDTH: begin
                    sw_cfg_reg <= cfg_data;
                end
                CFG_SRC_HEIGHT: begin
                    sh_cfg_reg <= cfg_data;
                end
                CFG_THUMB_WIDTH: begin
                    tw_cfg_reg <= cfg_data[6:0];
                end
                CFG_THUMB_HEIGHT: begin
                    th_cfg_reg <= cfg_data;
                end
                default: begin
                    sw_cfg_reg <= sw_cfg_reg;
                end
            endcase
        end
    end

    // Sequencer.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            dirty_reg     <= 1'b1;
            col_reg       <= '0;
            row_reg       <= '0;
            thumb_row_reg <= '0;
            top_reg       <= '0;
            bottom_reg    <= '0;
            xstep_reg     <= '0;
            ystep_reg     <= '0;
            dx_reg        <= '0;
            x0_reg        <= '0;
            cur_bank_reg  <= 1'b0;
            valid0_reg    <= '0;
            valid1_reg    <= '0;
            adv_reg       <= 1'b0;
            cont_reg      <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            // In ST_E_OUT the output register is reloaded below instead.
            if (m_valid_reg && m_ready && (state_reg != ST_E_OUT)) begin
                m_valid_reg <= 1'b0;
            end
            if (cfg_write_en) begin
                dirty_reg <= 1'b1;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (dirty_reg) begin
                        // New sizes: recompute the steps and rescan cells from the left.
                        if (!cfg_write_en) begin
                            dirty_reg <= 1'b0;
                        end
                        dx_reg    <= '0;
                        x0_reg    <= '0;
                        state_reg <= ST_CFG_XW;
                    end else if (accept) begin
                        if (col_reg == 16'd0 && row_reg == 16'd0) begin
                            thumb_row_reg <= '0;
                            top_reg       <= '0;
                            bottom_reg    <= ystep_reg;
                            valid0_reg    <= '0;
                            valid1_reg    <= '0;
                        end
                        state_reg <= ST_WY;
                    end
                end
                ST_CFG_XW: begin
                    if (step_stat.done && !step_stat.busy) begin
                        xstep_reg <= step_q;
                        state_reg <= ST_CFG_YW;
                    end
                end
                ST_CFG_YW: begin
                    if (step_stat.done && !step_stat.busy) begin
                        ystep_reg <= step_q;
                        state_reg <= ST_IDLE;
                    end
                end
                ST_WY: begin
                    state_reg <= (tr17 < th17) ? ST_C_ADDR : ST_P_END;
                end
                ST_C_ADDR: begin
                    if ({1'b0, x1} <= {1'b0, cstart}) begin
                        // This cell ends before the pixel starts.
                        if (last_cell) begin
                            state_reg <= ST_P_END;
                        end else begin
                            dx_reg <= dx_reg + DX_W'(1);
                            x0_reg <= x0_reg + xstep_reg;
                        end
                    end else if (wx == 17'd0) begin
                        state_reg <= ST_P_END;
                    end else begin
                        adv_reg   <= ({1'b0, x1} <= cend) && !last_cell;
                        cont_reg  <= ({1'b0, x1} < cend) && !last_cell;
                        state_reg <= ST_C_MUL1;
                    end
                end
                ST_C_MUL1: begin
                    state_reg <= ST_C_MUL2;
                end
                ST_C_MUL2: begin
                    state_reg <= ST_C_ADD;
                end
                ST_C_ADD: begin
                    valid0_reg[dx_reg] <= 1'b1;
                    valid1_reg[dx_reg] <= 1'b1;
                    if (adv_reg) begin
                        dx_reg <= dx_reg + DX_W'(1);
                        x0_reg <= x0_reg + xstep_reg;
                    end
                    state_reg <= cont_reg ? ST_C_ADDR : ST_P_END;
                end
                ST_P_END: begin
                    if (row_done) begin
                        col_reg <= '0;
                        dx_reg  <= '0;
                        x0_reg  <= '0;
                        if (emit_cond) begin
                            state_reg <= ST_E_RD;
                        end else begin
                            row_reg   <= (({1'b0, row_reg} + 17'd1) >= {1'b0, eff_sh}) ?
                                         16'd0 : (row_reg + 16'd1);
                            state_reg <= ST_IDLE;
                        end
                    end else begin
                        col_reg   <= col_reg + 16'd1;
                        state_reg <= ST_IDLE;
                    end
                end
                ST_E_RD: begin
                    state_reg <= ST_E_MUL;
                end
                ST_E_MUL: begin
                    state_reg <= ST_E_NUM;
                end
                ST_E_NUM: begin
                    state_reg <= ST_E_WAIT;
                end
                ST_E_WAIT: begin
                    if (stat_r.done && !stat_r.busy) begin
                        state_reg <= ST_E_OUT;
                    end
                end
                ST_E_OUT: begin
                    if (out_free) begin
                        m_valid_reg <= 1'b1;
                        if (last_cell) begin
                            state_reg <= ST_E_SWAP;
                        end else begin
                            dx_reg    <= dx_reg + DX_W'(1);
                            x0_reg    <= x0_reg + xstep_reg;
                            state_reg <= ST_E_RD;
                        end
                    end
                end
                ST_E_SWAP: begin
                    // The next-row bank becomes current; the old current bank is emptied.
                    cur_bank_reg <= !cur_bank_reg;
                    if (cur_bank_reg) begin
                        valid1_reg <= '0;
                    end else begin
                        valid0_reg <= '0;
                    end
                    thumb_row_reg <= new_tr;
                    top_reg       <= bottom_reg;
                    bottom_reg    <= (({1'b0, new_tr} + 17'd1) >= th17) ?
                                     srch : (bottom_reg + ystep_reg);
                    row_reg       <= (({1'b0, row_reg} + 17'd1) >= {1'b0, eff_sh}) ?
                                     16'd0 : (row_reg + 16'd1);
                    dx_reg        <= '0;
                    x0_reg        <= '0;
                    state_reg     <= ST_IDLE;
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        if (accept) begin
            pix_reg <= s_pixel_rgb565;
        end
        if (state_reg == ST_WY) begin
            wy0_reg <= wy0_c;
            wy1_reg <= wy1_c;
        end
        if (state_reg == ST_C_ADDR) begin
            wx_reg <= wx;
        end
        if (state_reg == ST_C_MUL1) begin
            p0_reg <= p0_c;
            p1_reg <= p1_c;
        end
        if (state_reg == ST_C_MUL2) begin
            r0_reg <= r0_c;
            g0_reg <= g0_c;
            b0_reg <= b0_c;
            r1_reg <= r1_c;
            g1_reg <= g1_c;
            b1_reg <= b1_c;
        end
        if (state_reg == ST_E_MUL) begin
            total_reg <= total_c;
        end
        if (state_reg == ST_E_WAIT) begin
            px_reg <= px_c;
        end
        if (state_reg == ST_E_OUT && out_free) begin
            thumb_pixel_reg <= px_reg;
            row_last_reg    <= last_cell;
            frame_last_reg  <= last_cell && ((tr17 + 17'd1) >= th17);
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_thumb_pixel = thumb_pixel_reg;
    assign m_row_last    = row_last_reg;
    assign m_frame_last  = frame_last_reg;

`ifndef SYNTHESIS
    a_dx_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_C_ADDR || state_reg == ST_E_RD) |-> ((7'(dx_reg) + 7'd1) <= eff_tw))
        else $error("cell index beyond thumbnail width");

    a_frame_last_on_row_end: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (!frame_last_reg || row_last_reg))
        else $error("frame end flagged on a pixel that does not end a row");

    a_div_lockstep: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_E_WAIT) |-> (stat_r == stat_g && stat_r == stat_b))
        else $error("component dividers out of step");

    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |-> (!step_stat.busy && !stat_r.busy))
        else $error("pixel taken while a divider runs");
`endif

endmodule
